@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/brfr_pkg.sv @@
// shared types and constants for the boot response frame receiver
// no dependencies
package brfr_pkg;

    localparam int BRFR_MAX_PAYLOAD = 512;

    localparam logic [7:0]  SOF_BYTE       = 8'h5A;
    localparam logic [7:0]  TYPE_ACK       = 8'hA1;
    localparam logic [7:0]  TYPE_NAK       = 8'hA2;
    localparam logic [7:0]  TYPE_ABORT     = 8'hA3;
    localparam logic [7:0]  TYPE_CMD       = 8'hA4;
    localparam logic [7:0]  TYPE_PING_RESP = 8'hA7;
    localparam logic [7:0]  ECHO_OFF       = 8'hFF;
    localparam logic [7:0]  MIN_PARAMS     = 8'd2;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_RD_ERR  = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIMEOUT   = 3'd1,
        ST_READ_ERR  = 3'd2,
        ST_FRAME_ERR = 3'd3,
        ST_NAK       = 3'd4,
        ST_ABORT     = 3'd5,
        ST_RESP_ERR  = 3'd6,
        ST_DEV_ERR   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_ACK1    = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_PING    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        REG_REPLY_MODE = 2'd0,
        REG_MATCH_TAG  = 2'd1,
        REG_ECHO_VALUE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic       reply_mode;
        logic [7:0] match_tag;
        logic [7:0] echo_value;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{reply_mode: 1'b0, match_tag: 8'hA0,
                                   echo_value: 8'hFF};

    typedef struct packed {
        phase_t      phase;
        logic [9:0]  byte_count;
        logic [15:0] payload_length;
        logic [15:0] running_crc;
        logic [15:0] received_crc;
        logic [7:0]  reply_tag;
        logic [7:0]  param_count;
        logic [31:0] first_param;
        logic [31:0] second_param;
    } frame_t;

    localparam frame_t FRAME_CLEAR = '{phase: PH_START, default: '0};

    typedef struct packed {
        status_t     status;
        logic [31:0] device_status;
        logic [31:0] reply_value;
    } result_t;

endpackage

@@ rtl/brfr_core.sv @@
// per-byte frame parser: next frame state and status result for one item
// depends on brfr_pkg
module brfr_core #(
    parameter int MAX_PAYLOAD = brfr_pkg::BRFR_MAX_PAYLOAD
) (
    input  brfr_pkg::frame_t  frame,
    input  brfr_pkg::cfg_t    cfg,
    input  brfr_pkg::op_t     op,
    input  logic [7:0]        rx_byte,
    output brfr_pkg::frame_t  frame_next,
    output logic              result_valid,
    output brfr_pkg::result_t result
);
    import brfr_pkg::*;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    frame_t     upd;
    logic       fire;
    logic       fire_finish;
    status_t    code;
    status_t    fin_code;
    logic       fin_params;
    logic [16:0] need_len;
    logic [9:0] idx;

    assign idx = frame.byte_count;

    // end-of-frame checks on the updated frame
    always_comb
    begin
        need_len   = {7'd0, upd.param_count, 2'b00} + 17'd4;
        fin_params = 1'b0;
        if (upd.running_crc != upd.received_crc)
            fin_code = ST_FRAME_ERR;
        else if (upd.payload_length < 16'd4 || upd.reply_tag != cfg.match_tag)
            fin_code = ST_RESP_ERR;
        else if (upd.param_count < MIN_PARAMS || {1'b0, upd.payload_length} < need_len)
            fin_code = ST_RESP_ERR;
        else if (upd.first_param != 32'd0)
        begin
            fin_code   = ST_DEV_ERR;
            fin_params = 1'b1;
        end
        else if (cfg.echo_value != ECHO_OFF &&
                 upd.second_param != {24'd0, cfg.echo_value})
        begin
            fin_code   = ST_RESP_ERR;
            fin_params = 1'b1;
        end
        else
        begin
            fin_code   = ST_OK;
            fin_params = 1'b1;
        end
    end

    always_comb
    begin
        upd         = frame;
        fire        = 1'b0;
        fire_finish = 1'b0;
        code        = ST_OK;
        case (op)
            OP_TIMEOUT:
            begin
                fire = 1'b1;
                code = ST_TIMEOUT;
            end
            OP_RD_ERR:
            begin
                fire = 1'b1;
                code = ST_READ_ERR;
            end
            OP_BYTE:
            begin
                case (frame.phase)
                    PH_START:
                    begin
                        upd.reply_tag = rx_byte;
                        if (cfg.reply_mode)
                        begin
                            upd.running_crc = crc_byte(16'd0, rx_byte);
                            upd.byte_count  = 10'd1;
                            upd.phase       = PH_PING;
                        end
                        else
                            upd.phase = PH_ACK1;
                    end
                    PH_ACK1:
                    begin
                        if (frame.reply_tag != SOF_BYTE)
                        begin
                            fire = 1'b1;
                            code = ST_FRAME_ERR;
                        end
                        else if (rx_byte == TYPE_NAK)
                        begin
                            fire = 1'b1;
                            code = ST_NAK;
                        end
                        else if (rx_byte == TYPE_ABORT)
                        begin
                            fire = 1'b1;
                            code = ST_ABORT;
                        end
                        else if (rx_byte != TYPE_ACK)
                        begin
                            fire = 1'b1;
                            code = ST_FRAME_ERR;
                        end
                        else
                        begin
                            upd.reply_tag   = 8'd0;
                            upd.byte_count  = 10'd0;
                            upd.running_crc = 16'd0;
                            upd.phase       = PH_HEADER;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (idx < 10'd4)
                            upd.running_crc = crc_byte(frame.running_crc, rx_byte);
                        upd.byte_count = idx + 10'd1;
                        case (idx)
                            10'd0: upd.received_crc = {8'd0, rx_byte};
                            10'd1:
                            begin
                                if (frame.received_crc != {8'd0, SOF_BYTE} ||
                                    rx_byte != TYPE_CMD)
                                begin
                                    fire = 1'b1;
                                    code = ST_FRAME_ERR;
                                end
                            end
                            10'd2: upd.payload_length = {8'd0, rx_byte};
                            10'd3: upd.payload_length = {rx_byte, frame.payload_length[7:0]};
                            10'd4: upd.received_crc = {8'd0, rx_byte};
                            default:
                            begin
                                upd.received_crc = frame.received_crc | {rx_byte, 8'd0};
                                if (frame.payload_length > 16'(MAX_PAYLOAD))
                                begin
                                    fire = 1'b1;
                                    code = ST_FRAME_ERR;
                                end
                                else if (frame.payload_length == 16'd0)
                                    fire_finish = 1'b1;
                                else
                                begin
                                    upd.byte_count = 10'd0;
                                    upd.phase      = PH_PAYLOAD;
                                end
                            end
                        endcase
                    end
                    PH_PAYLOAD:
                    begin
                        upd.running_crc = crc_byte(frame.running_crc, rx_byte);
                        if (idx == 10'd0)
                            upd.reply_tag = rx_byte;
                        else if (idx == 10'd3)
                            upd.param_count = rx_byte;
                        else if (idx >= 10'd4 && idx < 10'd8)
                            upd.first_param[{idx[1:0], 3'b000} +: 8] =
                                frame.first_param[{idx[1:0], 3'b000} +: 8] | rx_byte;
                        else if (idx >= 10'd8 && idx < 10'd12)
                            upd.second_param[{idx[1:0], 3'b000} +: 8] =
                                frame.second_param[{idx[1:0], 3'b000} +: 8] | rx_byte;
                        if ({7'd0, idx} + 17'd1 >= {1'b0, frame.payload_length})
                            fire_finish = 1'b1;
                        else
                            upd.byte_count = idx + 10'd1;
                    end
                    PH_PING:
                    begin
                        if (idx == 10'd1)
                            upd.param_count = rx_byte;
                        if (idx < 10'd8)
                            upd.running_crc = crc_byte(frame.running_crc, rx_byte);
                        upd.byte_count = idx + 10'd1;
                        if (idx == 10'd8)
                            upd.received_crc = {8'd0, rx_byte};
                        else if (idx >= 10'd9)
                        begin
                            upd.received_crc = frame.received_crc | {rx_byte, 8'd0};
                            fire = 1'b1;
                            if (frame.reply_tag != SOF_BYTE ||
                                frame.param_count != TYPE_PING_RESP)
                                code = ST_FRAME_ERR;
                            else if (upd.running_crc != upd.received_crc)
                                code = ST_FRAME_ERR;
                            else
                                code = ST_OK;
                        end
                    end
                    default: upd = FRAME_CLEAR;
                endcase
            end
            default: upd = frame;
        endcase
    end

    always_comb
    begin
        result_valid = fire || fire_finish;
        result       = '{status: ST_OK, default: '0};
        frame_next   = upd;
        if (result_valid)
        begin
            frame_next    = FRAME_CLEAR;
            result.status = fire_finish ? fin_code : code;
            if (fire_finish && fin_params)
            begin
                result.device_status = upd.first_param;
                result.reply_value   = upd.second_param;
            end
        end
    end

endmodule

@@ rtl/boot_response_frame_receiver_top.sv @@
// top level of the boot response frame receiver: input stage, frame state,
// result register and configuration registers; depends on brfr_pkg, brfr_core
//
// channel   direction  handshake                 contents
// s_axis    in         s_axis_tvalid/tready      op in tuser, rx_byte in tdata
// m_axis    out        m_axis_tvalid/tready      status in tuser, params in tdata
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// one item per cycle unless a held result stalls the core: an item waits in the
// input register, then the byte-wide crc update and field capture in brfr_core
// run combinationally into the frame state and the result register
// a result is offered once the item that ends the reply leaves the input register
// a stalled result holds; the input register takes one more item only if empty
// rst_n clears frame state and valid flags and resets the configuration at once
module boot_response_frame_receiver_top #(
    parameter int MAX_PAYLOAD = brfr_pkg::BRFR_MAX_PAYLOAD
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] device_status, [63:32] reply_value
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import brfr_pkg::*;

    // input register
    logic       in_valid_reg;
    op_t        in_op_reg;
    logic [7:0] in_byte_reg;

    // frame state and configuration
    frame_t frame_reg;
    frame_t frame_next;
    cfg_t   cfg_reg;

    // result register
    logic    m_valid_reg;
    result_t m_result_reg;

    logic    advance;
    logic    core_fire;
    result_t core_result;

    // item moves into the core when the result register can take its output
    assign advance       = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    brfr_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .frame        (frame_reg),
        .cfg          (cfg_reg),
        .op           (in_op_reg),
        .rx_byte      (in_byte_reg),
        .frame_next   (frame_next),
        .result_valid (core_fire),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_op_reg    <= OP_BYTE;
            in_byte_reg  <= 8'd0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
            if (s_axis_tvalid)
            begin
                in_op_reg   <= op_t'(s_axis_tuser);
                in_byte_reg <= s_axis_tdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_reg <= FRAME_CLEAR;
        else if (advance)
            frame_reg <= frame_next;
    end

    // result register: load on a new status, clear once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg  <= 1'b0;
            m_result_reg <= '{status: ST_OK, default: '0};
        end
        else if (advance && core_fire)
        begin
            m_valid_reg  <= 1'b1;
            m_result_reg <= core_result;
        end
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_REPLY_MODE: cfg_reg.reply_mode <= cfg_data[0];
                REG_MATCH_TAG:  cfg_reg.match_tag  <= cfg_data;
                REG_ECHO_VALUE: cfg_reg.echo_value <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_result_reg.reply_value, m_result_reg.device_status};
    assign m_axis_tuser  = m_result_reg.status;

endmodule

@@ rtl/brfr_checker.sv @@
// port-level checks for the boot response frame receiver, bound to the top
// depends on brfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module brfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import brfr_pkg::*;

    logic        out_stall;
    logic [66:0] out_word;
    logic        early_exit;
    logic        ok_or_dev;
    logic        is_dev_err;
    logic        dev_flag;

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_word   = {m_axis_tuser, m_axis_tdata};
    assign early_exit = m_axis_tuser == ST_TIMEOUT || m_axis_tuser == ST_READ_ERR ||
                        m_axis_tuser == ST_FRAME_ERR || m_axis_tuser == ST_NAK ||
                        m_axis_tuser == ST_ABORT;
    assign ok_or_dev  = m_axis_tuser == ST_OK || m_axis_tuser == ST_DEV_ERR;
    assign is_dev_err = m_axis_tuser == ST_DEV_ERR;
    assign dev_flag   = m_axis_tdata[31:0] != 32'd0;

    // a stalled result keeps its contents
    `ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "stalled result changed")

    // with the result register empty the input side never stalls
    `ASSERT_ALWAYS(a_in_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

    // early-exit statuses carry no parameters
    `ASSERT_ALWAYS(a_no_params, m_axis_tvalid && early_exit |-> m_axis_tdata == 64'd0, "params on error")

    // an ok reply has a zero device status, a device error a nonzero one
    `ASSERT_ALWAYS(a_dev_status, m_axis_tvalid && ok_or_dev |-> dev_flag == is_dev_err, "device status")

endmodule

bind boot_response_frame_receiver_top brfr_checker u_brfr_checker (.*);
